### src/rgb_hue_cycle_fader_core_macros.svh
// Assertion macros for the checker file.
`ifndef RGB_HUE_CYCLE_FADER_CORE_MACROS_SVH
`define RGB_HUE_CYCLE_FADER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhcf: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhcf: next-cycle property failed");

`endif

### src/rhcf_pkg.sv
package rhcf_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned LedIdxW = 4;

  // Fade step and channel ceiling
  localparam logic [ChanW-1:0] FadeStep = 8'd4;
  localparam logic [ChanW-1:0] ChanMax  = 8'd255;

  // One LED table word
  typedef struct packed {
    logic [CountW-1:0] hold;
    logic [CountW-1:0] skip;
    logic [ChanW-1:0]  blue;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  red;
  } led_entry_t;

  // Port strobes of the LED table
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctrl_t;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdTick = 1'b1
  } command_e;

  typedef enum logic {
    StIdle = 1'b0,
    StWalk = 1'b1
  } walk_state_e;

endpackage

### src/rgb_hue_cycle_fader_core.sv
// Colour-wheel LED fader. A load transfer (tuser low) writes one LED's colour and
// hold setting and gives no result; an index at or beyond NUM_LEDS is dropped.
// A tick transfer (tuser high) walks the whole LED table through a single
// synchronous-read memory, one entry per cycle read-modify-write while the output
// is not stalled, and sends one result per LED in index order with tlast on the
// final one. A tick occupies the input side until the walk ends; output
// back-pressure stretches the walk, since the one-deep read stage waits for the
// output register. No clearing pass is needed after reset: the table starts all
// zero.
module rgb_hue_cycle_fader_core
  import rhcf_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // led_index[3:0], hold_ticks[7:4], init_red[15:8], init_green[23:16],
  // init_blue[31:24]
  input  logic [31:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_index[3:0], red[11:4], green[19:12], blue[27:20], zero[31:28]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned IdxW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned CntW = $clog2(NUM_LEDS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_LEDS - 1);

  // Input fields
  logic [LedIdxW-1:0] led_index;
  logic [CountW-1:0]  hold_ticks;
  logic [ChanW-1:0]   init_red;
  logic [ChanW-1:0]   init_green;
  logic [ChanW-1:0]   init_blue;
  command_e           command;

  assign led_index  = s_axis_tdata[3:0];
  assign hold_ticks = s_axis_tdata[7:4];
  assign init_red   = s_axis_tdata[15:8];
  assign init_green = s_axis_tdata[23:16];
  assign init_blue  = s_axis_tdata[31:24];
  assign command    = command_e'(s_axis_tuser);

  walk_state_e        state_q, state_d;
  logic [CntW-1:0]    issue_q, issue_d;
  logic [IdxW-1:0]    rd_idx_q;
  logic               rd_vld_q, rd_vld_d;
  logic               out_vld_q;
  logic [LedIdxW-1:0] out_idx_q;
  logic [ChanW-1:0]   out_red_q;
  logic [ChanW-1:0]   out_green_q;
  logic [ChanW-1:0]   out_blue_q;
  logic               out_last_q;

  logic            in_xfer;
  logic            load_ok;
  logic            tick_start;
  logic            advance;
  logic            last_entry;
  ram_ctrl_t       ram_ctrl;
  logic [IdxW-1:0] wr_idx;
  led_entry_t      wr_data;
  led_entry_t      rd_data;
  led_entry_t      upd_entry;

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_ok       = (int'(led_index) < int'(NUM_LEDS));
  assign tick_start    = in_xfer && (command == CmdTick);

  // Read stage moves on when the output register is free or being emptied
  assign advance    = rd_vld_q && (!out_vld_q || m_axis_tready);
  assign last_entry = (rd_idx_q == LastIdx);

  // Table port control
  always_comb begin
    ram_ctrl.rd_en = (state_q == StWalk) && (issue_q < CntW'(NUM_LEDS))
                     && (!rd_vld_q || advance);
    ram_ctrl.wr_en = advance || (in_xfer && (command == CmdLoad) && load_ok);
    if (advance) begin
      wr_idx  = rd_idx_q;
      wr_data = upd_entry;
    end else begin
      wr_idx  = IdxW'(led_index);
      wr_data = '{hold: hold_ticks, skip: '0, blue: init_blue,
                  green: init_green, red: init_red};
    end
  end

  rhcf_led_ram #(
    .NUM_LEDS (NUM_LEDS),
    .IdxW     (IdxW)
  ) u_led_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ram_ctrl),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_idx_i  (issue_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  rhcf_entry_update u_entry_update (
    .entry_i (rd_data),
    .entry_o (upd_entry)
  );

  // Walk sequencer
  always_comb begin
    state_d  = state_q;
    issue_d  = issue_q;
    rd_vld_d = rd_vld_q;
    if (ram_ctrl.rd_en) begin
      issue_d  = issue_q + CntW'(1);
      rd_vld_d = 1'b1;
    end else if (advance) begin
      rd_vld_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (tick_start) begin
          state_d = StWalk;
          issue_d = '0;
        end
      end
      StWalk: begin
        if (advance && last_entry) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Read index and output payload
  always_ff @(posedge clk_i) begin
    if (ram_ctrl.rd_en) begin
      rd_idx_q <= issue_q[IdxW-1:0];
    end
    if (advance) begin
      out_idx_q   <= LedIdxW'(rd_idx_q);
      out_red_q   <= upd_entry.red;
      out_green_q <= upd_entry.green;
      out_blue_q  <= upd_entry.blue;
      out_last_q  <= last_entry;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_blue_q, out_green_q, out_red_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### src/rhcf_led_ram.sv
module rhcf_led_ram
  import rhcf_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 16,
  parameter int unsigned IdxW     = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ram_ctrl_t       ctrl_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  led_entry_t      wr_data_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output led_entry_t      rd_data_o
);

  led_entry_t          mem_q [NUM_LEDS];
  led_entry_t          rd_word_q;
  logic [NUM_LEDS-1:0] valid_q;
  logic                rd_valid_q;

  // Table storage, synchronous read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_word_q <= mem_q[rd_idx_i];
    end
  end

  // Written marks; an unwritten entry reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_word_q : '0;

endmodule

### src/rhcf_entry_update.sv
module rhcf_entry_update
  import rhcf_pkg::*;
(
  input  led_entry_t entry_i,
  output led_entry_t entry_o
);

  function automatic logic [ChanW-1:0] fade_up(input logic [ChanW-1:0] v);
    fade_up = (v > (ChanMax - FadeStep)) ? ChanMax : v + FadeStep;
  endfunction

  function automatic logic [ChanW-1:0] fade_down(input logic [ChanW-1:0] v);
    fade_down = (v < FadeStep) ? '0 : v - FadeStep;
  endfunction

  // Skip count, then the seven hue-wheel rules in order
  always_comb begin
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    r       = entry_i.red;
    g       = entry_i.green;
    b       = entry_i.blue;
    entry_o = entry_i;
    if (entry_i.skip < entry_i.hold) begin
      entry_o.skip = entry_i.skip + CountW'(1);
    end else begin
      entry_o.skip = '0;
      if (r < ChanMax && g == '0 && b == '0)      r = fade_up(r);
      if (r == ChanMax && g < ChanMax && b == '0) g = fade_up(g);
      if (r > '0 && g == ChanMax && b == '0)      r = fade_down(r);
      if (r == '0 && g == ChanMax && b < ChanMax) b = fade_up(b);
      if (r == '0 && g > '0 && b == ChanMax)      g = fade_down(g);
      if (r < ChanMax && g == '0 && b == ChanMax) r = fade_up(r);
      if (r == ChanMax && g == '0 && b > '0)      b = fade_down(b);
      entry_o.red   = r;
      entry_o.green = g;
      entry_o.blue  = b;
    end
  end

endmodule

### src/rhcf_checker.sv
`include "rgb_hue_cycle_fader_core_macros.svh"

module rhcf_checker #(
  parameter int unsigned NUM_LEDS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [3:0] last_index;
  logic       tick_xfer;
  logic       load_xfer;

  assign last_index = 4'(NUM_LEDS - 1);
  assign tick_xfer  = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign load_xfer  = s_axis_tvalid && s_axis_tready && !s_axis_tuser;

  // A stalled result holds
  `RHCF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // The marked result reports the final LED
  `RHCF_ASSERT_IMPL(a_last_index, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[3:0] == last_index)

  // A tick occupies the input side while the table is walked
  `RHCF_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, tick_xfer, !s_axis_tready)

  // A load never produces a result
  `RHCF_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, load_xfer && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind rgb_hue_cycle_fader_core rhcf_checker #(
  .NUM_LEDS (NUM_LEDS)
) u_rhcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/rgb_hue_cycle_fader_core_tb.sv
module rgb_hue_cycle_fader_core_tb;
  import rhcf_pkg::*;

  localparam int NumLeds = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // led_index[3:0], hold_ticks[7:4], init_red[15:8], init_green[23:16], init_blue[31:24]
  logic [31:0] s_axis_tdata;
  // command[0]
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // out_index[3:0], red[11:4], green[19:12], blue[27:20], zero[31:28]
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  // One colour report as it should leave the block
  typedef struct packed {
    logic [LedIdxW-1:0] idx;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic               last;
  } led_colour_t;

  led_colour_t colour_due[$];

  // Shadow copy of the LED table
  logic [ChanW-1:0]  red_tab   [NumLeds];
  logic [ChanW-1:0]  green_tab [NumLeds];
  logic [ChanW-1:0]  blue_tab  [NumLeds];
  logic [CountW-1:0] skip_tab  [NumLeds];
  logic [CountW-1:0] hold_tab  [NumLeds];

  int tx_idle_pct;
  int rx_stall_pct;
  int errors;
  int loads_sent;
  int ticks_sent;
  int colours_seen;

  rgb_hue_cycle_fader_core #(
    .NUM_LEDS(NumLeds)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(20 * 400000);
    $display("rgb_hue_cycle_fader_core_tb NOT OK");
    $finish;
  end

  // Saturating fades by one step
  function automatic logic [ChanW-1:0] fade_up(input logic [ChanW-1:0] v);
    return (v > ChanMax - FadeStep) ? ChanMax : v + FadeStep;
  endfunction

  function automatic logic [ChanW-1:0] fade_down(input logic [ChanW-1:0] v);
    return (v < FadeStep) ? '0 : v - FadeStep;
  endfunction

  // Update the shadow table for one accepted transfer, queue the colours it causes
  task automatic predict_colours(input command_e cmd, input logic [31:0] data);
    logic [ChanW-1:0] r, g, b;
    int idx;
    led_colour_t c;
    if (cmd == CmdLoad) begin
      idx = int'(data[3:0]);
      if (idx < NumLeds) begin
        hold_tab[idx]  = data[7:4];
        red_tab[idx]   = data[15:8];
        green_tab[idx] = data[23:16];
        blue_tab[idx]  = data[31:24];
        skip_tab[idx]  = '0;
      end
    end else begin
      for (int k = 0; k < NumLeds; k++) begin
        if (skip_tab[k] < hold_tab[k]) begin
          skip_tab[k] = skip_tab[k] + 1'b1;
        end else begin
          skip_tab[k] = '0;
          r = red_tab[k];
          g = green_tab[k];
          b = blue_tab[k];
          // hue wheel, each rule sees what the earlier ones left
          if (r < ChanMax && g == 0 && b == 0) r = fade_up(r);
          if (r == ChanMax && g < ChanMax && b == 0) g = fade_up(g);
          if (r > 0 && g == ChanMax && b == 0) r = fade_down(r);
          if (r == 0 && g == ChanMax && b < ChanMax) b = fade_up(b);
          if (r == 0 && g > 0 && b == ChanMax) g = fade_down(g);
          if (r < ChanMax && g == 0 && b == ChanMax) r = fade_up(r);
          if (r == ChanMax && g == 0 && b > 0) b = fade_down(b);
          red_tab[k]   = r;
          green_tab[k] = g;
          blue_tab[k]  = b;
        end
        c.idx   = k[LedIdxW-1:0];
        c.red   = red_tab[k];
        c.green = green_tab[k];
        c.blue  = blue_tab[k];
        c.last  = (k == NumLeds - 1);
        colour_due.push_back(c);
      end
    end
  endtask

  // Send one transfer, with a random idle gap first; tvalid stays high afterwards
  task automatic push_item(input command_e cmd, input logic [31:0] data);
    int gap;
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_colours(cmd, data);
    if (cmd == CmdLoad) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic load_led(input logic [3:0] idx, input logic [3:0] hold,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    push_item(CmdLoad, {b, g, r, hold, idx});
  endtask

  task automatic tick_all();
    push_item(CmdTick, $urandom());
  endtask

  // Hold the input side until every queued colour is out
  task automatic wait_drained(input int tail);
    s_axis_tvalid <= 1'b0;
    while (colour_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Mostly colours on the wheel rim, some arbitrary ones
  task automatic pick_colour(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    logic [7:0] ch [3];
    int hi, lo, mid;
    if ($urandom_range(99) < 20) begin
      r = 8'($urandom_range(255));
      g = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
    end else begin
      hi  = $urandom_range(2);
      lo  = (hi + 1 + $urandom_range(1)) % 3;
      mid = 3 - hi - lo;
      ch[hi] = ($urandom_range(99) < 20) ? 8'($urandom_range(255, 248)) : ChanMax;
      ch[lo] = '0;
      case ($urandom_range(2))
        0: ch[mid] = 8'($urandom_range(7));
        1: ch[mid] = 8'($urandom_range(255, 248));
        default: ch[mid] = 8'($urandom_range(255));
      endcase
      r = ch[0];
      g = ch[1];
      b = ch[2];
    end
  endtask

  task automatic random_load();
    logic [7:0] r, g, b;
    logic [3:0] hold;
    pick_colour(r, g, b);
    hold = ($urandom_range(99) < 85) ? 4'($urandom_range(2)) : 4'($urandom_range(15));
    load_led(4'($urandom_range(NumLeds - 1)), hold, r, g, b);
  endtask

  // Groups of loads followed by a few ticks
  task automatic run_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(4)) begin
        random_load();
        sent++;
      end
      repeat ($urandom_range(3, 1)) begin
        tick_all();
        sent++;
      end
    end
  endtask

  // Reset state, every wheel rule, saturation and rule chaining
  task automatic test_directed_wheel();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    tick_all();
    load_led(4'd0,  4'd0,  8'd253, 8'd0,   8'd0);
    load_led(4'd1,  4'd0,  8'd255, 8'd255, 8'd0);
    load_led(4'd2,  4'd0,  8'd0,   8'd255, 8'd2);
    load_led(4'd3,  4'd0,  8'd0,   8'd1,   8'd255);
    load_led(4'd4,  4'd0,  8'd3,   8'd0,   8'd255);
    load_led(4'd5,  4'd0,  8'd255, 8'd0,   8'd3);
    load_led(4'd6,  4'd0,  8'd255, 8'd255, 8'd255);
    load_led(4'd7,  4'd1,  8'd128, 8'd0,   8'd0);
    load_led(4'd8,  4'd0,  8'd0,   8'd255, 8'd255);
    load_led(4'd9,  4'd0,  8'd255, 8'd0,   8'd255);
    load_led(4'd10, 4'd0,  8'd1,   8'd255, 8'd0);
    load_led(4'd15, 4'd15, 8'd0,   8'd0,   8'd0);
    push_item(CmdTick, 32'hffff_ffff);
    push_item(CmdTick, 32'h0000_0000);
    tick_all();
    tick_all();
  endtask

  task automatic test_free_flow();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_random(100);
  endtask

  task automatic test_sender_idle();
    tx_idle_pct  = 67;
    rx_stall_pct = 0;
    run_random(100);
  endtask

  task automatic test_receiver_stall();
    tx_idle_pct  = 0;
    rx_stall_pct = 67;
    run_random(100);
  endtask

  task automatic test_both_idle();
    tx_idle_pct  = 36;
    rx_stall_pct = 36;
    run_random(120);
  endtask

  // Sender waits for a fully drained output after every tick
  task automatic test_drain_pause();
    tx_idle_pct  = 36;
    rx_stall_pct = 36;
    repeat (40) begin
      if ($urandom_range(1)) begin
        random_load();
      end else begin
        tick_all();
        wait_drained(4);
      end
    end
  endtask

  // Output side: check each transfer, then pick tready for the next cycle
  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
    errors++;
  endtask

  initial begin : colour_checker
    led_colour_t want;
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        colours_seen++;
        if (colour_due.size() == 0) begin
          $display("%0t: unexpected colour transfer, expected none got 0x%08h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = colour_due.pop_front();
          if (m_axis_tdata[3:0] !== want.idx)    report_field("out_index", want.idx,
                                                              m_axis_tdata[3:0]);
          if (m_axis_tdata[11:4] !== want.red)   report_field("red", want.red,
                                                              m_axis_tdata[11:4]);
          if (m_axis_tdata[19:12] !== want.green) report_field("green", want.green,
                                                               m_axis_tdata[19:12]);
          if (m_axis_tdata[27:20] !== want.blue) report_field("blue", want.blue,
                                                              m_axis_tdata[27:20]);
          if (m_axis_tlast !== want.last)        report_field("last", want.last,
                                                              m_axis_tlast);
          if (m_axis_tdata[31:28] !== 4'd0)      report_field("pad", 0,
                                                              m_axis_tdata[31:28]);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    errors       = 0;
    loads_sent   = 0;
    ticks_sent   = 0;
    colours_seen = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int k = 0; k < NumLeds; k++) begin
      red_tab[k]   = '0;
      green_tab[k] = '0;
      blue_tab[k]  = '0;
      skip_tab[k]  = '0;
      hold_tab[k]  = '0;
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CmdLoad;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_wheel();
    test_free_flow();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_drain_pause();
    wait_drained(40);

    $display("Sent %0d loads and %0d ticks, checked %0d colour transfers,", loads_sent,
             ticks_sent, colours_seen);
    $display("with free flow, sender gaps, output stalls, both, and drained pauses.");
    if (errors == 0) begin
      $display("rgb_hue_cycle_fader_core_tb OK");
    end else begin
      $display("rgb_hue_cycle_fader_core_tb NOT OK");
    end
    $finish;
  end

endmodule
